/* rtl/core/slw_pkg.sv */
// Shared constants, register indexes and pipeline stage types for the soft luma wipe mixer.
`default_nettype none

package slw_pkg;

    // Sample and channel geometry
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned NUM_CH = 3;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_WIPE_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIPE_DIRECTION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_SOFTNESS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLOW_STRENGTH  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXTRA_MIX      = 3'd4;

    // Register limits
    localparam logic [8:0] THR_MAX  = 9'd256;
    localparam logic [8:0] MIX_MAX  = 9'd256;
    localparam logic [7:0] SOFT_MAX = 8'd128;

    // Q8 weight arithmetic
    localparam logic [8:0]  WEIGHT_ONE = 9'd256;
    localparam logic [17:0] MIX_ROUND  = 18'd128;
    localparam logic [16:0] BLEND_ROUND = 17'd128;

    // Span used for the glow when the edge is hard, and the minimum span
    localparam logic [7:0] GLOW_SPAN = 8'd8;
    localparam logic [7:0] SPAN_MIN  = 8'd1;

    // Reciprocal of the span: ceil(2^RECIP_SHIFT / span)
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned RECIP_W     = 25;
    localparam int unsigned PROD_W      = 41;

    // Pipeline depth
    localparam int unsigned NUM_STAGES = 6;

    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [7:0]         span;
        logic [RECIP_W-1:0] recip;
        logic               soft_on;
    } span_info_t;

    typedef struct packed {
        pix_t dst;
        pix_t src;
        logic last;
    } pixel_pair_t;

    // Edge distance (two's complement) and its magnitude
    typedef struct packed {
        logic [9:0]  edge_diff;
        logic [8:0]  dist_abs;
        pixel_pair_t px;
    } s0_t;

    // Ramp and glow numerators
    typedef struct packed {
        logic        use_ramp;
        logic [8:0]  w_fixed;
        logic        glow_on;
        logic [15:0] ramp_num;
        logic [15:0] glow_num;
        pixel_pair_t px;
    } s1_t;

    // Blend weight and glow addend
    typedef struct packed {
        logic [8:0]  weight;
        logic [7:0]  glow_add;
        pixel_pair_t px;
    } s2_t;

    // Blended channels before glow
    typedef struct packed {
        pix_t       mixed;
        logic [7:0] glow_add;
        logic       last;
    } s4_t;

    // Final result
    typedef struct packed {
        pix_t pix;
        logic last;
    } s5_t;

endpackage

`default_nettype wire

/* rtl/core/soft_luma_wipe_pixel_mixer.sv */
// Top level of the soft luma wipe pixel mixer: config registers and six-stage pixel pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | pattern_level, dest_ch0..2, src_ch0..2,
//          |           |                    | last_pixel
//  out     | output    | out_valid/out_stall| out_ch0..2, frame_end
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel request per clock while in_stall is low; a result is registered in each stage in
// turn, from s0_reg to s5_reg, before it shows on the output.
// Stages: edge distance, ramp/glow numerators, reciprocal multiply, mix push, blend, glow add.
// Empty stages collapse, so in_stall is high only when every stage holds a pixel and out_stall
// is high. rst_n clears all valid bits and the config registers; the datapath has no reset.
// Config writes are taken in any cycle (cfg_ready is always high); the span reciprocal is
// registered in slw_recip from the stored softness and glow values.
`default_nettype none

module soft_luma_wipe_pixel_mixer (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [slw_pkg::PIX_W-1:0]           pattern_level,
    input  logic [slw_pkg::PIX_W-1:0]           dest_ch0,
    input  logic [slw_pkg::PIX_W-1:0]           dest_ch1,
    input  logic [slw_pkg::PIX_W-1:0]           dest_ch2,
    input  logic [slw_pkg::PIX_W-1:0]           src_ch0,
    input  logic [slw_pkg::PIX_W-1:0]           src_ch1,
    input  logic [slw_pkg::PIX_W-1:0]           src_ch2,
    input  logic                                last_pixel,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [slw_pkg::PIX_W-1:0]           out_ch0,
    output logic [slw_pkg::PIX_W-1:0]           out_ch1,
    output logic [slw_pkg::PIX_W-1:0]           out_ch2,
    output logic                                frame_end,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [slw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [slw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int unsigned NS = slw_pkg::NUM_STAGES;

    // Configuration registers (stored already saturated)
    logic [8:0] thr_reg;
    logic       dir_reg;
    logic [7:0] soft_reg;
    logic [7:0] glow_reg;
    logic [8:0] mix_reg;

    slw_pkg::span_info_t span_info;

    // Pipeline control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_in;
    logic [NS-1:0] stage_ready;

    // Pipeline data
    slw_pkg::s0_t s0_reg, s0_next;
    slw_pkg::s1_t s1_reg, s1_next;
    slw_pkg::s2_t s2_reg, s2_next;
    slw_pkg::s2_t s3_reg, s3_next;
    slw_pkg::s4_t s4_reg, s4_next;
    slw_pkg::s5_t s5_reg, s5_next;

    // Take config writes in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 9'd0;
            dir_reg  <= 1'b0;
            soft_reg <= 8'd0;
            glow_reg <= 8'd0;
            mix_reg  <= 9'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slw_pkg::CFG_WIPE_THRESHOLD:
                begin
                    thr_reg <= (cfg_data > slw_pkg::THR_MAX) ? slw_pkg::THR_MAX : cfg_data;
                end
                slw_pkg::CFG_WIPE_DIRECTION:
                begin
                    dir_reg <= cfg_data[0];
                end
                slw_pkg::CFG_EDGE_SOFTNESS:
                begin
                    soft_reg <= (cfg_data[7:0] > slw_pkg::SOFT_MAX) ? slw_pkg::SOFT_MAX
                                                                    : cfg_data[7:0];
                end
                slw_pkg::CFG_GLOW_STRENGTH:
                begin
                    glow_reg <= cfg_data[7:0];
                end
                slw_pkg::CFG_EXTRA_MIX:
                begin
                    mix_reg <= (cfg_data > slw_pkg::MIX_MAX) ? slw_pkg::MIX_MAX : cfg_data;
                end
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    slw_recip u_slw_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .softness  (soft_reg),
        .glow      (glow_reg),
        .span_info (span_info)
    );

    // Ready chain: a stage loads when it is empty or its successor moves
    always_comb
    begin
        stage_ready[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            stage_ready[k] = !v_reg[k] || stage_ready[k+1];
        end
    end

    assign in_stall = !stage_ready[0];
    assign v_in     = {v_reg[NS-2:0], in_valid};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (stage_ready[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    // Stage 0: signed edge distance and magnitude
    always_comb
    begin
        logic [9:0] thr10;
        logic [9:0] pat10;
        logic [9:0] neg;
        thr10 = {1'b0, thr_reg};
        pat10 = {2'b00, pattern_level};
        s0_next.edge_diff = dir_reg ? (thr10 - pat10) : (pat10 - thr10);
        neg               = 10'd0 - s0_next.edge_diff;
        s0_next.dist_abs  = s0_next.edge_diff[9] ? neg[8:0] : s0_next.edge_diff[8:0];
        s0_next.px.dst = {dest_ch2, dest_ch1, dest_ch0};
        s0_next.px.src = {src_ch2, src_ch1, src_ch0};
        s0_next.px.last = last_pixel;
    end

    // Stage 1: band test, fixed weights, ramp and glow numerators
    always_comb
    begin
        logic [7:0] span;
        logic       in_band;
        logic       nonneg;
        logic       pos;
        logic [9:0] dist_plus;
        logic [7:0] glow_dist;
        span      = span_info.span;
        in_band   = (s0_reg.dist_abs < {1'b0, span});
        nonneg    = !s0_reg.edge_diff[9];
        pos       = nonneg && (s0_reg.edge_diff != 10'd0);
        dist_plus = s0_reg.edge_diff + {2'b00, span};
        glow_dist = span - s0_reg.dist_abs[7:0];

        s1_next.use_ramp = span_info.soft_on && in_band;
        if (span_info.soft_on)
        begin
            s1_next.w_fixed = nonneg ? slw_pkg::WEIGHT_ONE : 9'd0;
        end
        else
        begin
            s1_next.w_fixed = pos ? slw_pkg::WEIGHT_ONE : 9'd0;
        end
        s1_next.glow_on  = (glow_reg != 8'd0) && in_band;
        // (dist + span) * 256 + span, with span below 256
        s1_next.ramp_num = {dist_plus[7:0], span};
        s1_next.glow_num = (16'(glow_reg) * 16'(glow_dist)) + 16'(span >> 1);
        s1_next.px       = s0_reg.px;
    end

    // Stage 2: divide by span through the reciprocal
    always_comb
    begin
        logic [slw_pkg::PROD_W-1:0] ramp_prod;
        logic [slw_pkg::PROD_W-1:0] glow_prod;
        ramp_prod = slw_pkg::PROD_W'(s1_reg.ramp_num) * slw_pkg::PROD_W'(span_info.recip);
        glow_prod = slw_pkg::PROD_W'(s1_reg.glow_num) * slw_pkg::PROD_W'(span_info.recip);
        s2_next.weight   = s1_reg.use_ramp
                         ? {1'b0, ramp_prod[slw_pkg::RECIP_SHIFT+8:slw_pkg::RECIP_SHIFT+1]}
                         : s1_reg.w_fixed;
        s2_next.glow_add = s1_reg.glow_on
                         ? glow_prod[slw_pkg::RECIP_SHIFT+7:slw_pkg::RECIP_SHIFT]
                         : 8'd0;
        s2_next.px       = s1_reg.px;
    end

    // Stage 3: push the weight toward the source by the mix amount
    always_comb
    begin
        logic [8:0]  inv;
        logic [17:0] push;
        inv  = slw_pkg::WEIGHT_ONE - s2_reg.weight;
        push = (18'(inv) * 18'(mix_reg)) + slw_pkg::MIX_ROUND;
        s3_next.weight   = s2_reg.weight + push[16:8];
        s3_next.glow_add = s2_reg.glow_add;
        s3_next.px       = s2_reg.px;
    end

    // Stage 4: rounded blend of each channel
    always_comb
    begin
        logic [8:0]  inv;
        logic [16:0] acc;
        inv = slw_pkg::WEIGHT_ONE - s3_reg.weight;
        s4_next.mixed = '0;
        for (int c = 0; c < slw_pkg::NUM_CH; c++)
        begin
            acc = (17'(s3_reg.px.dst[c]) * 17'(inv))
                + (17'(s3_reg.px.src[c]) * 17'(s3_reg.weight))
                + slw_pkg::BLEND_ROUND;
            s4_next.mixed[c] = acc[15:8];
        end
        s4_next.glow_add = s3_reg.glow_add;
        s4_next.last     = s3_reg.px.last;
    end

    // Stage 5: add glow to channel 0 and saturate
    always_comb
    begin
        logic [8:0] sum;
        sum = {1'b0, s4_reg.mixed[0]} + {1'b0, s4_reg.glow_add};
        s5_next.pix    = s4_reg.mixed;
        s5_next.pix[0] = sum[8] ? 8'hFF : sum[7:0];
        s5_next.last   = s4_reg.last;
    end

    // Load stage data where a request moves in
    always_ff @(posedge clk)
    begin
        if (stage_ready[0] && v_in[0])
        begin
            s0_reg <= s0_next;
        end
        if (stage_ready[1] && v_in[1])
        begin
            s1_reg <= s1_next;
        end
        if (stage_ready[2] && v_in[2])
        begin
            s2_reg <= s2_next;
        end
        if (stage_ready[3] && v_in[3])
        begin
            s3_reg <= s3_next;
        end
        if (stage_ready[4] && v_in[4])
        begin
            s4_reg <= s4_next;
        end
        if (stage_ready[5] && v_in[5])
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_ch0   = s5_reg.pix[0];
    assign out_ch1   = s5_reg.pix[1];
    assign out_ch2   = s5_reg.pix[2];
    assign frame_end = s5_reg.last;

endmodule

`default_nettype wire

/* rtl/core/slw_recip.sv */
// Span selection and span reciprocal lookup, registered.
`default_nettype none

module slw_recip (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           softness,
    input  logic [7:0]           glow,
    output slw_pkg::span_info_t  span_info
);

    localparam int unsigned TAB_DEPTH = 256;
    localparam int unsigned RW        = slw_pkg::RECIP_W;
    localparam int unsigned RECIP_ONE = 2 ** slw_pkg::RECIP_SHIFT;

    logic [RW-1:0]        recip_tab [TAB_DEPTH];
    slw_pkg::span_info_t  span_info_reg;
    slw_pkg::span_info_t  span_info_next;

    // Build the reciprocal table at elaboration; entry zero is never selected
    assign recip_tab[0] = RW'(RECIP_ONE);
    for (genvar i = 1; i < TAB_DEPTH; i++) begin : g_recip
        localparam int unsigned RECIP_VAL = (RECIP_ONE + i - 1) / i;
        assign recip_tab[i] = RW'(RECIP_VAL);
    end

    // Pick the span and look up its reciprocal
    always_comb
    begin
        span_info_next.soft_on = (softness != 8'd0);
        if (softness != 8'd0)
        begin
            span_info_next.span = softness;
        end
        else if (glow != 8'd0)
        begin
            span_info_next.span = slw_pkg::GLOW_SPAN;
        end
        else
        begin
            span_info_next.span = slw_pkg::SPAN_MIN;
        end
        span_info_next.recip = recip_tab[span_info_next.span];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_info_reg.span    <= slw_pkg::SPAN_MIN;
            span_info_reg.recip   <= RW'(RECIP_ONE);
            span_info_reg.soft_on <= 1'b0;
        end
        else
        begin
            span_info_reg <= span_info_next;
        end
    end

    assign span_info = span_info_reg;

endmodule

`default_nettype wire

/* rtl/core/slw_checker.sv */
// Port-level checks for the soft luma wipe mixer and the bind that attaches them.
`default_nettype none

module slw_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [slw_pkg::PIX_W-1:0]  out_ch0,
    input logic [slw_pkg::PIX_W-1:0]  out_ch1,
    input logic [slw_pkg::PIX_W-1:0]  out_ch2,
    input logic                       frame_end
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_ch0) && $stable(out_ch1)
                                  && $stable(out_ch2) && $stable(frame_end))
        else $error("stalled result changed or dropped");

    // Reset empties the pipe and frees the input by the following edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("pipeline not empty after reset");

    // Input backpressure only comes from a full pipe behind a stalled output
    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output can move");

    // A pending input request is taken whenever the output moves
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !out_stall |-> !in_stall)
        else $error("input request held while output is free");

endmodule

bind soft_luma_wipe_pixel_mixer slw_checker u_slw_checker (.*);

`default_nettype wire
